>>> rtl/core/zvac_pkg.sv
package zvac_pkg;

    localparam int ZONE_W    = 2;
    localparam int ZCMP_W    = 5;
    localparam int TEMP_W    = 15;
    localparam int THYS_W    = 13;
    localparam int CO2_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_LIMIT  = 8'd0,
        REG_TEMP_HYST   = 8'd1,
        REG_CO2_LIMIT   = 8'd2,
        REG_CO2_HYST    = 8'd3,
        REG_WALL_FROZEN = 8'd4,
        REG_COOLDOWN    = 8'd5
    } t_cfg_reg;

    localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST  = 15'd800;
    localparam logic [THYS_W-1:0] TEMP_HYST_RST   = 13'd100;
    localparam logic [CO2_W-1:0]  CO2_LIMIT_RST   = 16'd1000;
    localparam logic [CO2_W-1:0]  CO2_HYST_RST    = 16'd100;
    localparam logic [TEMP_W-1:0] WALL_FROZEN_RST = 15'h7F38;
    localparam logic [TIME_W-1:0] COOLDOWN_RST    = 32'd600000;

    localparam logic KIND_ROT  = 1'b0;
    localparam logic KIND_WARM = 1'b1;

    typedef struct packed {
        logic [TEMP_W-1:0] temp_limit;
        logic [THYS_W-1:0] temp_hyst;
        logic [CO2_W-1:0]  co2_limit;
        logic [CO2_W-1:0]  co2_hyst;
        logic [TEMP_W-1:0] wall_frozen;
        logic [TIME_W-1:0] cooldown;
    } t_cfg;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic              reading_valid;
        logic [TEMP_W-1:0] temperature;
        logic [CO2_W-1:0]  co2_level;
        logic [TIME_W-1:0] now_ms;
        logic              day_mode;
        logic [TEMP_W-1:0] wall_temperature;
        logic              alert_room;
    } t_item;

    typedef struct packed {
        logic [ZONE_W-1:0] zone_out;
        logic              damper_open;
        logic              damper_changed;
        logic              compressor_on;
        logic              compressor_changed;
        logic              alert_raise;
        logic              alert_kind;
        logic [TEMP_W-1:0] alert_temperature;
        logic [CO2_W-1:0]  alert_co2;
    } t_result;

endpackage

>>> rtl/core/zvac_cfg.sv
module zvac_cfg
    import zvac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit  <= TEMP_LIMIT_RST;
            r_cfg.temp_hyst   <= TEMP_HYST_RST;
            r_cfg.co2_limit   <= CO2_LIMIT_RST;
            r_cfg.co2_hyst    <= CO2_HYST_RST;
            r_cfg.wall_frozen <= WALL_FROZEN_RST;
            r_cfg.cooldown    <= COOLDOWN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_TEMP_LIMIT:  r_cfg.temp_limit  <= i_cfg_data[TEMP_W-1:0];
                REG_TEMP_HYST:   r_cfg.temp_hyst   <= i_cfg_data[THYS_W-1:0];
                REG_CO2_LIMIT:   r_cfg.co2_limit   <= i_cfg_data[CO2_W-1:0];
                REG_CO2_HYST:    r_cfg.co2_hyst    <= i_cfg_data[CO2_W-1:0];
                REG_WALL_FROZEN: r_cfg.wall_frozen <= i_cfg_data[TEMP_W-1:0];
                REG_COOLDOWN:    r_cfg.cooldown    <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/zvac_zone_core.sv
module zvac_zone_core
    import zvac_pkg::*;
#(
    parameter int ZONES = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // damper command mirrors the alarm latch, so one bit per zone serves both
    logic [ZONES-1:0]  r_latch;
    logic [ZONES-1:0]  r_sent;
    logic [TIME_W-1:0] r_last [ZONES];
    logic              r_comp;

    logic [ZONES-1:0]  hit;
    logic              zone_ok;
    logic              sel_latch;
    logic              sel_sent;
    logic [TIME_W-1:0] sel_last;
    logic              rot;
    logic              warm;
    logic              clr_rot;
    logic              clr_warm;
    logic              upd;
    logic              latch_new;
    logic              due;
    logic              raise;
    logic              want;
    logic [TIME_W-1:0] elapsed;

    assign zone_ok = {3'b000, i_item.zone} < ZCMP_W'(ZONES);

    always_comb begin
        hit       = '0;
        sel_latch = 1'b0;
        sel_sent  = 1'b0;
        sel_last  = '0;
        for (int i = 0; i < ZONES; i++) begin
            hit[i] = {3'b000, i_item.zone} == ZCMP_W'(i);
            if (hit[i]) begin
                sel_latch = r_latch[i];
                sel_sent  = r_sent[i];
                sel_last  = r_last[i];
            end
        end
    end

    assign rot  = i_item.co2_level > i_cfg.co2_limit;
    assign warm = $signed(i_item.temperature) > $signed(i_cfg.temp_limit);

    assign clr_rot = $signed({2'b00, i_item.co2_level}) <
                     ($signed({2'b00, i_cfg.co2_limit}) - $signed({2'b00, i_cfg.co2_hyst}));
    assign clr_warm = $signed({{2{i_item.temperature[TEMP_W-1]}}, i_item.temperature}) <
                      ($signed({{2{i_cfg.temp_limit[TEMP_W-1]}}, i_cfg.temp_limit}) -
                       $signed({4'b0000, i_cfg.temp_hyst}));

    assign upd       = i_item.reading_valid && zone_ok;
    assign latch_new = (sel_latch || rot || warm) && !(clr_rot && clr_warm);
    assign elapsed   = i_item.now_ms - sel_last;
    assign due       = !sel_sent || (elapsed > i_cfg.cooldown);
    assign raise     = upd && latch_new && due && i_item.alert_room;
    assign want      = i_item.day_mode &&
                       ($signed(i_item.wall_temperature) > $signed(i_cfg.wall_frozen));

    always_comb begin
        o_result.zone_out           = i_item.zone;
        o_result.damper_open        = zone_ok ? (upd ? latch_new : sel_latch) : 1'b0;
        o_result.damper_changed     = upd && (latch_new != sel_latch);
        o_result.compressor_on      = want;
        o_result.compressor_changed = want != r_comp;
        o_result.alert_raise        = raise;
        o_result.alert_kind         = raise ? (rot ? KIND_ROT : KIND_WARM) : KIND_ROT;
        o_result.alert_temperature  = raise ? i_item.temperature : '0;
        o_result.alert_co2          = raise ? i_item.co2_level : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_sent  <= '0;
            r_comp  <= 1'b0;
        end else if (i_fire) begin
            r_comp <= want;
            for (int i = 0; i < ZONES; i++) begin
                if (upd && hit[i]) begin
                    r_latch[i] <= latch_new;
                    if (!latch_new) begin
                        r_sent[i] <= 1'b0;
                    end else if (raise) begin
                        r_sent[i] <= 1'b1;
                    end
                end
            end
        end
    end

    // timestamp only matters once the sent flag is set, so no reset
    always_ff @(posedge i_clk) begin
        if (i_fire && raise) begin
            for (int i = 0; i < ZONES; i++) begin
                if (hit[i]) begin
                    r_last[i] <= i_item.now_ms;
                end
            end
        end
    end

endmodule

>>> rtl/core/zoned_vent_alarm_controller_top.sv
// Zoned vent alarm controller. One zone reading per beat, accepted in every cycle
// without gaps while the sink takes results; each reading gives exactly one
// result beat on the master side, passing the input register, then one
// compare-and-update stage that writes the per-zone latch, cooldown state and
// the result register. The per-zone state is updated in that single stage, so
// consecutive readings of the same zone need no spacing. A result that the sink
// does not take holds in the output register and the input register keeps one
// more beat before the slave side deasserts ready. Latch, sent and compressor
// state are cleared by reset, timestamps are not; no clearing pass. Configuration
// writes are taken in any cycle but are meant for when the block is idle.
module zoned_vent_alarm_controller_top
    import zvac_pkg::*;
#(
    parameter int ZONES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // temperature, co2_level, now_ms, day_mode, wall_temperature, alert_room
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // zone, reading_valid
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // damper_open, damper_changed, compressor_on, compressor_changed,
    // alert_raise, alert_temperature, alert_co2, zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // zone_out, alert_kind
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    t_cfg    cfg;
    t_item   s_item;
    t_item   r_in;
    logic    r_in_valid;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;
    logic    fire;

    assign s_item.temperature      = i_s_axis_tdata[14:0];
    assign s_item.co2_level        = i_s_axis_tdata[30:15];
    assign s_item.now_ms           = i_s_axis_tdata[62:31];
    assign s_item.day_mode         = i_s_axis_tdata[63];
    assign s_item.wall_temperature = i_s_axis_tdata[78:64];
    assign s_item.alert_room       = i_s_axis_tdata[79];
    assign s_item.zone             = i_s_axis_tuser[1:0];
    assign s_item.reading_valid    = i_s_axis_tuser[2];

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = advance && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || advance;

    zvac_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    zvac_zone_core #(
        .ZONES (ZONES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= s_item;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.alert_co2, r_out.alert_temperature,
                              r_out.alert_raise, r_out.compressor_changed,
                              r_out.compressor_on, r_out.damper_changed,
                              r_out.damper_open};
    assign o_m_axis_tuser  = {r_out.alert_kind, r_out.zone_out};

`ifndef SYNTHESIS
    // a held input beat means the output side is stalled
    a_in_hold_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_s_axis_tready) |-> (r_out_valid && !i_m_axis_tready))
        else $error("input register held without output stall");

    // a processed beat always lands in the output register
    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed beat lost");

    // alert payload stays zero unless an alert is raised
    a_alert_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[4]) |->
        (o_m_axis_tdata[35:5] == 31'd0 && o_m_axis_tuser[2] == KIND_ROT))
        else $error("alert fields set without alert");
`endif

endmodule
